// File: hw/rtl/isfd_pkg.sv
// Shared types and constants for the IMU serial frame decoder.
`default_nettype none

package isfd_pkg;

    localparam int unsigned WIN_LEN   = 11;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned RAW_W     = 16;
    localparam int unsigned SCALE_W   = 29;
    localparam int unsigned PROD_W    = RAW_W + SCALE_W + 1;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned AXIS_W    = 28;
    localparam int unsigned N_AXES    = 3;

    localparam logic [BYTE_W-1:0] HEAD_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] KIND_BASE = 8'h51;

    localparam logic [1:0] KIND_ACC   = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_ANGLE = 2'd2;

    // Scale constants, round(c * 2^32)
    localparam logic [SCALE_W-1:0] SCALE_ACC   = 29'd20552090;
    localparam logic [SCALE_W-1:0] SCALE_GYRO  = 29'd262144000;
    localparam logic [SCALE_W-1:0] SCALE_ANGLE = 29'd23592960;

    typedef logic [N_AXES-1:0][RAW_W-1:0]  t_raw_axes;
    typedef logic [N_AXES-1:0][AXIS_W-1:0] t_axes;

    typedef struct packed {
        logic      ok;
        logic [1:0] kind;
        t_raw_axes raw;
    } t_frame;

    function automatic logic [SCALE_W-1:0] kind_scale(input logic [1:0] kind);
        logic [SCALE_W-1:0] k;
        case (kind)
            KIND_ACC:   k = SCALE_ACC;
            KIND_GYRO:  k = SCALE_GYRO;
            KIND_ANGLE: k = SCALE_ANGLE;
            default:    k = '0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/isfd_window.sv
// Eleven-byte shift window with header, kind and checksum check.
`default_nettype none

module isfd_window (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_load,
    input  wire                             i_drain,
    input  wire  [isfd_pkg::BYTE_W-1:0]     i_byte,
    output logic                            o_pend,
    output isfd_pkg::t_frame                o_frame
);

    logic [isfd_pkg::BYTE_W-1:0] r_win [isfd_pkg::WIN_LEN];
    logic                        r_pend;
    logic                        n_pend;

    logic [isfd_pkg::BYTE_W-1:0] w_s01, w_s23, w_s45, w_s67, w_s89;
    logic [isfd_pkg::BYTE_W-1:0] w_sum;
    logic [isfd_pkg::BYTE_W-1:0] w_kind_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < isfd_pkg::WIN_LEN; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_load) begin
            for (int i = 0; i < isfd_pkg::WIN_LEN - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[isfd_pkg::WIN_LEN-1] <= i_byte;
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (i_load) begin
            n_pend = 1'b1;
        end else if (i_drain) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= n_pend;
        end
    end

    // checksum: low byte of the sum of bytes 0..9, wraps naturally at 8 bits
    assign w_s01 = r_win[0] + r_win[1];
    assign w_s23 = r_win[2] + r_win[3];
    assign w_s45 = r_win[4] + r_win[5];
    assign w_s67 = r_win[6] + r_win[7];
    assign w_s89 = r_win[8] + r_win[9];
    assign w_sum = (w_s01 + w_s23) + (w_s45 + w_s67) + w_s89;

    assign w_kind_off = r_win[1] - isfd_pkg::KIND_BASE;

    assign o_pend        = r_pend;
    assign o_frame.ok    = (r_win[0] == isfd_pkg::HEAD_BYTE)
                         && (w_kind_off < 8'd3)
                         && (w_sum == r_win[isfd_pkg::WIN_LEN-1]);
    assign o_frame.kind  = w_kind_off[1:0];
    assign o_frame.raw[0] = {r_win[3], r_win[2]};
    assign o_frame.raw[1] = {r_win[5], r_win[4]};
    assign o_frame.raw[2] = {r_win[7], r_win[6]};

endmodule

`default_nettype wire

// File: hw/rtl/isfd_scale.sv
// Per-axis constant multiply with round-to-nearest into the result register.
`default_nettype none

module isfd_scale (
    input  wire                     i_clk,
    input  wire                     i_load,
    input  isfd_pkg::t_frame        i_frame,
    output logic [1:0]              o_kind,
    output isfd_pkg::t_axes         o_axes
);

    localparam logic signed [isfd_pkg::PROD_W-1:0] ROUND_HALF =
        isfd_pkg::PROD_W'(1) <<< (isfd_pkg::FRAC_W - 1);

    logic [1:0]                   r_kind;
    isfd_pkg::t_axes              r_axes;
    isfd_pkg::t_axes              n_axes;
    logic signed [isfd_pkg::SCALE_W:0] w_k;

    assign w_k = $signed({1'b0, isfd_pkg::kind_scale(i_frame.kind)});

    for (genvar g = 0; g < isfd_pkg::N_AXES; g++) begin : g_lane
        logic signed [isfd_pkg::PROD_W-1:0] w_prod;
        logic signed [isfd_pkg::PROD_W-1:0] w_rnd;
        assign w_prod = $signed(i_frame.raw[g]) * w_k;
        assign w_rnd  = w_prod + ROUND_HALF;
        // floor shift; low field bits are exact since the value fits
        assign n_axes[g] = w_rnd[isfd_pkg::FRAC_W +: isfd_pkg::AXIS_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_frame.kind;
            r_axes <= n_axes;
        end
    end

    assign o_kind = r_kind;
    assign o_axes = r_axes;

endmodule

`default_nettype wire

// File: hw/rtl/imu_serial_frame_decoder_core.sv
// Top level: IMU serial frame decoder, window stage and scaled result register.
// Path: the word that completes a frame is taken into the window register,
// and a valid frame then moves into the result register once it is free.
// Throughput: one word per cycle; the window and result stages stall only
// when a finished result is held and another valid frame is waiting.
// Reset (synchronous, active low) clears the window to zero and drops all valids.
`default_nettype none

module imu_serial_frame_decoder_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire  [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [1:0]                  o_frame_kind,
    output logic signed [27:0]          o_axis_x,
    output logic signed [27:0]          o_axis_y,
    output logic signed [27:0]          o_axis_z
);

    isfd_pkg::t_frame w_frame;
    isfd_pkg::t_axes  w_axes;
    logic             w_pend;
    logic             w_out_free;
    logic             w_win_done;
    logic             w_load;
    logic             w_res_load;
    logic             r_out_vld;
    logic             n_out_vld;

    assign w_out_free = !r_out_vld || !i_out_stall;
    // a window with no frame drains at once; a frame waits for the result register
    assign w_win_done = w_pend && (!w_frame.ok || w_out_free);
    assign w_res_load = w_pend && w_frame.ok && w_out_free;
    assign o_in_stall = w_pend && !w_win_done;
    assign w_load     = i_in_valid && !o_in_stall;

    isfd_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_drain (w_win_done),
        .i_byte  (i_rx_byte),
        .o_pend  (w_pend),
        .o_frame (w_frame)
    );

    isfd_scale u_scale (
        .i_clk   (i_clk),
        .i_load  (w_res_load),
        .i_frame (w_frame),
        .o_kind  (o_frame_kind),
        .o_axes  (w_axes)
    );

    assign n_out_vld = w_res_load || (r_out_vld && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_axis_x    = $signed(w_axes[0]);
    assign o_axis_y    = $signed(w_axes[1]);
    assign o_axis_z    = $signed(w_axes[2]);

    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_load |=> (o_out_valid && o_frame_kind != 2'd3))
        else $error("result loaded with bad kind or without valid");

    a_load_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> w_pend)
        else $error("accepted word not pending in window");

    a_stall_needs_pend: assert property (@(posedge i_clk)
        o_in_stall |-> (w_pend && w_frame.ok))
        else $error("input stalled without a waiting frame");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !w_pend))
        else $error("reset did not clear valids");

endmodule

`default_nettype wire
